// ----- hw/rtl/mie_pkg.sv -----
// Shared widths and controller/datapath command and status types for the modular inverse block.
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

   localparam int WIDTH = 32;
   // Bezout coefficients stay within the modulus in magnitude; two extra bits hold sign and carry.
   localparam int SW = WIDTH + 2;
   localparam int CNT_W = $clog2(WIDTH);

   typedef logic [WIDTH-1:0] word_type;
   typedef logic signed [SW-1:0] coef_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic shift;
      logic sub_step;
      logic update;
      logic fold;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic r1_zero;
      logic can_shift;
      logic cnt_zero;
   } dp_sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/mie_if.sv -----
// Valid/ready channel interfaces for the request and response beats.
`timescale 1ns / 1ps
`default_nettype none

interface mie_req_if ();
   logic                 valid;
   logic                 ready;
   mie_pkg::word_type    value_in;
   mie_pkg::word_type    modulus_in;

   modport source (output valid, output value_in, output modulus_in, input ready);
   modport sink (input valid, input value_in, input modulus_in, output ready);
endinterface

interface mie_rsp_if ();
   logic                 valid;
   logic                 ready;
   mie_pkg::word_type    inverse_out;
   mie_pkg::word_type    gcd_out;

   modport source (output valid, output inverse_out, output gcd_out, input ready);
   modport sink (input valid, input inverse_out, input gcd_out, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mie_ctrl.sv -----
// Sequencing state machine for the Euclid steps, the shift-subtract divider and the result beat.
`timescale 1ns / 1ps
`default_nettype none

module mie_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output mie_pkg::dp_cmd_type      cmd,
   input  wire mie_pkg::dp_sts_type sts
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_ALIGN  = 3'd2;
   localparam logic [2:0] ST_SUB    = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;
   localparam logic [2:0] ST_FOLD   = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.r1_zero) begin
               state_in = ST_FOLD;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            if (sts.can_shift) begin
               cmd.shift = 1'b1;
            end else begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            cmd.sub_step = 1'b1;
            if (sts.cnt_zero) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A new result beat may only be written once the previous one has left.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.out_load)
      else $error("result beat overwritten while stalled");

endmodule

`default_nettype wire

// ----- hw/rtl/mie_dp.sv -----
// Datapath: remainder and coefficient registers, shift-subtract divider, fold and result registers.
`timescale 1ns / 1ps
`default_nettype none

module mie_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mie_pkg::dp_cmd_type cmd,
   output mie_pkg::dp_sts_type      sts,
   input  wire mie_pkg::word_type   value_in,
   input  wire mie_pkg::word_type   modulus_in,
   output mie_pkg::word_type        inverse_out,
   output mie_pkg::word_type        gcd_out
);

   mie_pkg::word_type r0_ff, r1_ff, rem_ff, dsr_ff, mod_ff, red_ff;
   mie_pkg::word_type inv_ff, gcd_ff;
   mie_pkg::coef_type s0_ff, s1_ff, acc_ff;
   mie_pkg::cnt_type  cnt_ff;
   logic              neg_ff;

   logic [mie_pkg::WIDTH:0] dsr_dbl;
   logic                    qbit;
   mie_pkg::coef_type       acc_in;
   logic [mie_pkg::SW-1:0]  mag;
   logic [mie_pkg::SW-1:0]  mod_ext;
   logic [mie_pkg::SW-1:0]  mag_red;
   mie_pkg::word_type       inv_in;

   assign dsr_dbl = {dsr_ff, 1'b0};
   assign qbit    = (rem_ff >= dsr_ff);
   assign acc_in  = mie_pkg::coef_type'(acc_ff <<< 1) + (qbit ? s1_ff : '0);

   assign sts.r1_zero   = (r1_ff == '0);
   assign sts.can_shift = (dsr_dbl <= {1'b0, rem_ff});
   assign sts.cnt_zero  = (cnt_ff == '0);

   assign mag     = s0_ff[mie_pkg::SW-1] ? (~s0_ff + 1'b1) : s0_ff;
   assign mod_ext = {2'b00, mod_ff};
   assign mag_red = (mag >= mod_ext) ? (mag - mod_ext) : mag;

   always_comb begin
      priority if (mod_ff == '0) begin
         inv_in = '0;
      end else if (red_ff == '0) begin
         inv_in = mod_ff;
      end else if (neg_ff) begin
         inv_in = mod_ff - red_ff;
      end else begin
         inv_in = red_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r0_ff  <= value_in;
         r1_ff  <= modulus_in;
         mod_ff <= modulus_in;
         s0_ff  <= mie_pkg::coef_type'(1);
         s1_ff  <= '0;
      end
      if (cmd.div_start) begin
         rem_ff <= r0_ff;
         dsr_ff <= r1_ff;
         cnt_ff <= '0;
         acc_ff <= '0;
      end
      if (cmd.shift) begin
         dsr_ff <= dsr_dbl[mie_pkg::WIDTH-1:0];
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.sub_step) begin
         if (qbit) begin
            rem_ff <= rem_ff - dsr_ff;
         end
         dsr_ff <= dsr_ff >> 1;
         cnt_ff <= cnt_ff - 1'b1;
         acc_ff <= acc_in;
      end
      if (cmd.update) begin
         r0_ff <= r1_ff;
         r1_ff <= rem_ff;
         s0_ff <= s1_ff;
         s1_ff <= s0_ff - acc_ff;
      end
      if (cmd.fold) begin
         red_ff <= mag_red[mie_pkg::WIDTH-1:0];
         neg_ff <= s0_ff[mie_pkg::SW-1];
      end
      if (cmd.out_load) begin
         inv_ff <= inv_in;
         gcd_ff <= r0_ff;
      end
   end

   assign inverse_out = inv_ff;
   assign gcd_out     = gcd_ff;

   // The last subtract step leaves a remainder below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.sub_step && sts.cnt_zero) |=> (rem_ff < r1_ff))
      else $error("division remainder not below divisor");

   // Each Euclid step strictly shrinks the remainder pair.
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (r1_ff < r0_ff))
      else $error("remainder sequence did not decrease");

   // The folded magnitude lies below a nonzero modulus.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.fold && (mod_ff != '0)) |=> (red_ff < mod_ff))
      else $error("folded coefficient out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/modular_inverse_ext_euclid.sv -----
// Top level of the extended Euclidean modular inverse block.
//
//   Channel | Port    | Dir | Payload
//   --------+---------+-----+---------------------------------
//   request | req_if  | in  | value_in, modulus_in
//   result  | rsp_if  | out | inverse_out, gcd_out
//
// One item at a time. Each Euclid step runs a check, the align shifts and the subtract steps of
// the shift-subtract divider, and then an update. Synchronous active-high reset clears the
// controller and the result valid. A stalled result beat holds in its register; the next item
// is accepted and worked on meanwhile, waiting only before its own result is written.
`timescale 1ns / 1ps
`default_nettype none

module modular_inverse_ext_euclid (
   input  wire logic  clock,
   input  wire logic  reset,
   mie_req_if.sink    req_if,
   mie_rsp_if.source  rsp_if
);

   mie_pkg::dp_cmd_type cmd;
   mie_pkg::dp_sts_type sts;

   mie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   mie_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .value_in    (req_if.value_in),
      .modulus_in  (req_if.modulus_in),
      .inverse_out (rsp_if.inverse_out),
      .gcd_out     (rsp_if.gcd_out)
   );

endmodule

`default_nettype wire

// ----- sim/modular_inverse_ext_euclid_test.sv -----
// Self-checking testbench for the extended Euclidean modular inverse block.
`timescale 1ns / 1ps

typedef struct {
   mie_pkg::word_type inverse;
   mie_pkg::word_type gcd;
} euclid_result_type;

class inverse_scoreboard;
   euclid_result_type pending_inverses[$];
   int errors = 0;

   // Works out the folded Bezout coefficient and the gcd for one accepted request beat.
   function void note_operands(mie_pkg::word_type value, mie_pkg::word_type modulus);
      bit [63:0] r0, r1, s0, s1, quot, r_next, s_next, mag, rem;
      euclid_result_type res;
      r0 = 64'(value);
      r1 = 64'(modulus);
      s0 = 64'd1;
      s1 = 64'd0;
      while (r1 != 64'd0) begin
         quot = r0 / r1;
         r_next = r0 - quot * r1;
         s_next = s0 - quot * s1;
         r0 = r1;
         r1 = r_next;
         s0 = s1;
         s1 = s_next;
      end
      if (modulus == '0) begin
         res.inverse = '0;
      end else if (s0[63]) begin
         mag = 64'd0 - s0;
         rem = mag % 64'(modulus);
         res.inverse = (rem == 64'd0) ? modulus : mie_pkg::word_type'(64'(modulus) - rem);
      end else begin
         rem = s0 % 64'(modulus);
         res.inverse = (rem == 64'd0) ? modulus : mie_pkg::word_type'(rem);
      end
      res.gcd = mie_pkg::word_type'(r0);
      pending_inverses.push_back(res);
   endfunction

   function void check_result(mie_pkg::word_type inverse, mie_pkg::word_type gcd);
      euclid_result_type want;
      if (pending_inverses.size() == 0) begin
         errors++;
         $display("%0t: unexpected result beat inverse=%0d gcd=%0d", $time, inverse, gcd);
         return;
      end
      want = pending_inverses.pop_front();
      if (inverse !== want.inverse) begin
         errors++;
         $display("%0t: inverse_out expected %0d actual %0d", $time, want.inverse, inverse);
      end
      if (gcd !== want.gcd) begin
         errors++;
         $display("%0t: gcd_out expected %0d actual %0d", $time, want.gcd, gcd);
      end
   endfunction

   function int outstanding();
      return pending_inverses.size();
   endfunction
endclass

module modular_inverse_ext_euclid_test;

   localparam int RANDOM_ITEMS = 725;
   localparam int HOLD_OFF_CYCLES = 1200;
   localparam int QUIET_LIMIT = 20000;
   localparam int TAIL_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_off_go = 1'b0;

   mie_req_if req ();
   mie_rsp_if rsp ();

   inverse_scoreboard sb = new();

   int burst_left = 0;
   int gap_max = 40;
   int quiet_cycles = 0;

   modular_inverse_ext_euclid dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watches both channels, scores the beats and bounds the time with no traffic.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            sb.note_operands(req.value_in, req.modulus_in);
         end
         if (rsp.valid && rsp.ready) begin
            sb.check_result(rsp.inverse_out, rsp.gcd_out);
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Receiver: a changing ready pattern, with one long hold-off when the sender asks for it.
   initial begin
      int mode_left;
      int ready_pct;
      bit held;
      mode_left = 0;
      ready_pct = 100;
      held = 1'b0;
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go && !held) begin
            held = 1'b1;
            rsp.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp.ready <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               case ($urandom_range(0, 3))
                  0: ready_pct = 100;
                  1: ready_pct = 75;
                  2: ready_pct = 40;
                  default: ready_pct = 10;
               endcase
               mode_left = $urandom_range(20, 400);
            end
            mode_left--;
            rsp.ready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   task automatic send_item(mie_pkg::word_type value, mie_pkg::word_type modulus);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = (gap_max > 0) ? int'($urandom_range(0, gap_max)) : 0;
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req.valid <= 1'b1;
      req.value_in <= value;
      req.modulus_in <= modulus;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic send_random_item();
      mie_pkg::word_type value;
      mie_pkg::word_type modulus;
      mie_pkg::word_type factor;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         value = $urandom;
         modulus = $urandom;
      end else if (pick < 60) begin
         value = $urandom >> $urandom_range(0, 31);
         modulus = $urandom >> $urandom_range(0, 31);
      end else if (pick < 75) begin
         modulus = $urandom >> $urandom_range(16, 31);
         value = $urandom >> $urandom_range(0, 8);
      end else if (pick < 85) begin
         factor = $urandom_range(2, 255);
         value = factor * ($urandom >> $urandom_range(8, 31));
         modulus = factor * ($urandom >> $urandom_range(8, 31));
      end else if (pick < 93) begin
         modulus = $urandom >> $urandom_range(0, 31);
         value = modulus + $urandom_range(0, 4) - 2;
      end else begin
         modulus = $urandom >> $urandom_range(0, 31);
         case ($urandom_range(0, 2))
            0: value = '0;
            1: value = modulus;
            default: begin
               value = $urandom;
               modulus = 1;
            end
         endcase
      end
      if (modulus == '0) modulus = 1;
      send_item(value, modulus);
   endtask

   initial begin
      req.valid = 1'b0;
      req.value_in = '0;
      req.modulus_in = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: field extremes, zero value, zero modulus, value at or above modulus,
      // shared factors and the longest Euclid chain in 32 bits.
      send_item(32'd0, 32'd1);
      send_item(32'd0, 32'hFFFF_FFFF);
      send_item(32'd1, 32'd1);
      send_item(32'd1, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'd1);
      send_item(32'd3, 32'd7);
      send_item(32'd65537, 32'd3120);
      send_item(32'd17, 32'd3120);
      send_item(32'd7, 32'd3);
      send_item(32'd10, 32'd4);
      send_item(32'd12, 32'd18);
      send_item(32'd5, 32'd0);
      send_item(32'd0, 32'd0);
      send_item(32'hFFFF_FFFF, 32'd0);
      send_item(32'd2971215073, 32'd1836311903);
      send_item(32'd1836311903, 32'd2971215073);
      send_item(32'h8000_0000, 32'hFFFF_FFFF);
      send_item(32'hAAAA_AAAA, 32'h5555_5555);
      send_item(32'h5555_5555, 32'hAAAA_AAAA);
      send_item(32'd2, 32'h8000_0000);
      send_item(32'd65537, 32'hFFFF_FFFE);
      wait_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 100) hold_off_go <= 1'b1;
         if (i == 250) gap_max = 0;
         if (i == 350) gap_max = 300;
         if (i == 450) begin
            gap_max = 40;
            wait_drained();
         end
         send_random_item();
      end

      req.valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
